// ===== rtl/core/four_level_page_table_walker_core_macros.svh =====
// Assertion macros shared by the page table walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`ifndef SYNTH
`define FLTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fltw assertion failed");
`define FLTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fltw assertion failed");
`else
`define FLTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FLTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/fltw_pkg.sv =====
// Types, constants and helpers shared by the page table walker modules.
package fltw_pkg;

    localparam int VALUE_W    = 64;
    localparam int VA_W       = 48;
    localparam int IDX_W      = 9;
    localparam int OFFSET_W   = 12;
    localparam int ROOT_W     = 3;
    localparam int WIDX_W     = 12;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    localparam logic [1:0] FIRST_LEVEL = 2'd0;
    localparam logic [1:0] LAST_LEVEL  = 2'd3;

    typedef struct packed {
        logic                operation;
        logic [WIDX_W-1:0]   word_index;
        logic [VALUE_W-1:0]  write_data;
        logic [VA_W-1:0]     virt_addr;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  phys_addr;
        logic                mapped;
    } t_out_item;

    typedef struct packed {
        logic                start;
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    idx;
    } t_au_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ADDR,
        ST_CHECK,
        ST_DONE
    } t_state;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0: idx = va[47:39];
            2'd1: idx = va[38:30];
            2'd2: idx = va[29:21];
            2'd3: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/core/four_level_page_table_walker_core.sv =====
// Four level page table walker: table memory, sequencer and result register.
// After reset the block clears its table memory, one word per cycle, and stalls input
// meanwhile; root_frame may be written during that time. Each item gives one result.
// Word addresses come from one shared address unit followed by one RAM read port, so a
// translation costs at most four address-plus-read steps; it stops at an absent level.
// With MEM_WORDS a power of two the address unit forms an address in one registered
// add. Otherwise it reduces the value modulo MEM_WORDS sixteen bits per step, each
// step a reciprocal quotient estimate and then a subtraction. A result waits in an
// output register, and a further item is taken once the result has moved there.
`include "four_level_page_table_walker_core_macros.svh"

module four_level_page_table_walker_core #(
    parameter int MEM_WORDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fltw_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fltw_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [fltw_pkg::ROOT_W-1:0]   i_cfg_wdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

    fltw_pkg::t_state    r_state, n_state;
    fltw_pkg::t_in_item  r_item;
    fltw_pkg::t_out_item r_res, n_res;
    fltw_pkg::t_out_item r_out_item;
    logic                r_out_valid;
    logic [1:0]          r_level;
    logic [AW-1:0]       r_clr_addr;
    logic [fltw_pkg::ROOT_W-1:0] r_root;

    fltw_pkg::t_au_req   au_req;
    logic                au_start;
    logic                au_done;
    logic [AW-1:0]       au_addr;
    logic [1:0]          au_level;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [fltw_pkg::VALUE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [fltw_pkg::VALUE_W-1:0] ram_rdata;

    logic                is_write;
    logic                present;
    logic                last_level;
    logic                ld_res;
    logic                ld_out;
    logic                next_level;

    assign is_write   = (r_item.operation == fltw_pkg::OP_WRITE);
    assign present    = ram_rdata[0];
    assign last_level = (r_level == fltw_pkg::LAST_LEVEL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fltw_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_WORD) n_state = fltw_pkg::ST_IDLE;
            end
            fltw_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = fltw_pkg::ST_START;
            end
            fltw_pkg::ST_START: begin
                n_state = fltw_pkg::ST_ADDR;
            end
            fltw_pkg::ST_ADDR: begin
                if (au_done) n_state = is_write ? fltw_pkg::ST_DONE : fltw_pkg::ST_CHECK;
            end
            fltw_pkg::ST_CHECK: begin
                n_state = (!present || last_level) ? fltw_pkg::ST_DONE : fltw_pkg::ST_ADDR;
            end
            fltw_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = fltw_pkg::ST_IDLE;
            end
            default: n_state = fltw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        next_level   = 1'b0;
        au_start     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ld_res       = 1'b0;
        ld_out       = 1'b0;
        n_res        = '0;
        unique case (r_state)
            fltw_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            fltw_pkg::ST_START: begin
                au_start = 1'b1;
            end
            fltw_pkg::ST_ADDR: begin
                if (au_done) begin
                    ram_we = is_write;
                    ram_re = !is_write;
                    ld_res = is_write;
                end
            end
            fltw_pkg::ST_CHECK: begin
                if (!present || last_level) begin
                    ld_res = 1'b1;
                    if (present) begin
                        n_res.phys_addr = {ram_rdata[fltw_pkg::VALUE_W-1:fltw_pkg::OFFSET_W],
                                           r_item.virt_addr[fltw_pkg::OFFSET_W-1:0]};
                        n_res.mapped    = 1'b1;
                    end
                end else begin
                    au_start   = 1'b1;
                    next_level = 1'b1;
                end
            end
            fltw_pkg::ST_DONE: begin
                ld_out = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        au_req.start = au_start;
        au_level = (r_state == fltw_pkg::ST_CHECK) ? (r_level + 2'd1) : fltw_pkg::FIRST_LEVEL;
        if (r_state == fltw_pkg::ST_CHECK) begin
            au_req.value = {3'b000, ram_rdata[fltw_pkg::VALUE_W-1:fltw_pkg::OFFSET_W],
                            fltw_pkg::IDX_W'(0)};
        end else if (is_write) begin
            au_req.value = fltw_pkg::VALUE_W'(r_item.word_index);
        end else begin
            au_req.value = fltw_pkg::VALUE_W'({r_root, fltw_pkg::IDX_W'(0)});
        end
        au_req.idx = is_write ? '0 : fltw_pkg::level_index(r_item.virt_addr, au_level);
        ram_waddr  = (r_state == fltw_pkg::ST_CLEAR) ? r_clr_addr : au_addr;
        ram_wdata  = (r_state == fltw_pkg::ST_CLEAR) ? '0 : r_item.write_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fltw_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
            r_level     <= fltw_pkg::FIRST_LEVEL;
        end else begin
            r_state <= n_state;
            if (r_state == fltw_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == fltw_pkg::ST_START) begin
                r_level <= fltw_pkg::FIRST_LEVEL;
            end else if (next_level) begin
                r_level <= r_level + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fltw_pkg::ST_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (ld_res) begin
            r_res <= n_res;
        end
        if (ld_out) begin
            r_out_item <= r_res;
        end
    end

    fltw_addr_unit #(
        .MEM_WORDS (MEM_WORDS)
    ) u_addr_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (au_req),
        .o_done  (au_done),
        .o_addr  (au_addr)
    );

    fltw_ram #(
        .DATA_W (fltw_pkg::VALUE_W),
        .DEPTH  (MEM_WORDS)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (au_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != fltw_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `FLTW_ASSERT_IMP(a_check_after_read, i_clk, i_rst_n, r_state == fltw_pkg::ST_CHECK, $past(ram_re))
    `FLTW_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == fltw_pkg::ST_DONE))
    `FLTW_ASSERT_IMP(a_mapped_full_walk, i_clk, i_rst_n, (r_state == fltw_pkg::ST_DONE) && r_res.mapped, (r_item.operation == fltw_pkg::OP_XLATE) && (r_level == fltw_pkg::LAST_LEVEL))
    `FLTW_ASSERT_IMP(a_addr_done_in_addr, i_clk, i_rst_n, au_done, r_state == fltw_pkg::ST_ADDR)

endmodule

// ===== rtl/core/fltw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module fltw_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fltw_addr_unit.sv =====
// Shared word address unit: (value mod MEM_WORDS + idx) mod MEM_WORDS.
`include "four_level_page_table_walker_core_macros.svh"

module fltw_addr_unit #(
    parameter int MEM_WORDS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fltw_pkg::t_au_req            i_req,
    output logic                         o_done,
    output logic [$clog2(MEM_WORDS)-1:0] o_addr
);

    localparam int AW          = $clog2(MEM_WORDS);
    localparam bit IS_POW2     = ((1 << AW) == MEM_WORDS);
    localparam logic [AW:0] MOD = (AW+1)'(MEM_WORDS);

    logic          r_done;
    logic [AW-1:0] r_addr;

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_req.start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_req.start) begin
                    r_addr <= i_req.value[AW-1:0] + AW'(i_req.idx);
                end
            end
        end else begin : g_fold
            // Horner reduction, 16 value bits per step, MSB first: quotient estimate by
            // reciprocal multiply, then subtract with one correction
            localparam int CH_W  = 16;
            localparam int N_CH  = fltw_pkg::VALUE_W / CH_W;
            localparam int CNT_W = $clog2(N_CH + 1);
            localparam int T_W   = AW + CH_W;
            localparam int RC_W  = CH_W + 1;
            localparam int P_W   = T_W + RC_W;
            localparam logic [63:0]     RECIP_FULL = (64'd1 << T_W) / 64'(MEM_WORDS);
            localparam logic [RC_W-1:0] RECIP      = RC_W'(RECIP_FULL);

            logic                         r_busy;
            logic                         r_half;
            logic [CNT_W-1:0]             r_cnt;
            logic [fltw_pkg::VALUE_W-1:0] r_shift;
            logic [AW-1:0]                r_rem;
            logic [fltw_pkg::IDX_W-1:0]   r_idx;
            logic [T_W-1:0]               r_t;
            logic [CH_W-1:0]              r_q;
            logic [T_W-1:0]               step_t;
            logic [P_W-1:0]               prod_q;
            logic [T_W-1:0]               prod_m;
            logic [T_W-1:0]               diff;
            logic [AW:0]                  diff_r;
            logic [AW:0]                  sum_t;
            logic [AW:0]                  sum_r;

            always_comb begin
                step_t = {r_rem, r_shift[fltw_pkg::VALUE_W-1 -: CH_W]};
                prod_q = P_W'(step_t) * P_W'(RECIP);
                prod_m = T_W'(r_q) * T_W'(MOD);
                diff   = r_t - prod_m;
                diff_r = (diff[AW:0] >= MOD) ? (diff[AW:0] - MOD) : diff[AW:0];
                sum_t  = {1'b0, r_rem} + (AW+1)'(r_idx);
                sum_r  = (sum_t >= MOD) ? (sum_t - MOD) : sum_t;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_half <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_busy <= 1'b1;
                        r_half <= 1'b0;
                        r_cnt  <= CNT_W'(N_CH);
                    end else if (r_busy) begin
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_half <= !r_half;
                            if (r_half) begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_req.start) begin
                    r_shift <= i_req.value;
                    r_rem   <= '0;
                    r_idx   <= i_req.idx;
                end else if (r_busy) begin
                    if (r_cnt == '0) begin
                        r_addr <= sum_r[AW-1:0];
                    end else if (!r_half) begin
                        r_t <= step_t;
                        r_q <= prod_q[T_W +: CH_W];
                    end else begin
                        r_rem   <= diff_r[AW-1:0];
                        r_shift <= {r_shift[fltw_pkg::VALUE_W-CH_W-1:0], CH_W'(0)};
                    end
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_addr = r_addr;

    `FLTW_ASSERT_IMP(a_addr_in_range, i_clk, i_rst_n, o_done, int'(o_addr) < MEM_WORDS)

endmodule

// ===== tb/sv/fltw_walk_checker.sv =====
// Scoreboard for the page table walker: mirrors table memory and root frame, checks each result.
`timescale 1ns / 100ps

module fltw_walk_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  fltw_pkg::t_in_item            i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  fltw_pkg::t_out_item           i_out_item,
    input  logic                          i_cfg_we,
    input  logic [fltw_pkg::ROOT_W-1:0]   i_cfg_wdata,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_hits
);
    import fltw_pkg::*;

    localparam int                 TABLE_WORDS = 4096;
    localparam logic [VALUE_W-1:0] FRAME_MASK  = ~64'hFFF;

    logic [VALUE_W-1:0] table_words [TABLE_WORDS];
    logic [ROOT_W-1:0]  root_frame;
    t_out_item          results_due [$];
    int                 mismatches;
    int                 hits;

    function automatic t_out_item walk_tables(input logic [VA_W-1:0] va);
        t_out_item          res;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] entry;
        logic [VALUE_W-1:0] word;
        logic [IDX_W-1:0]   idx;
        res  = '0;
        base = VALUE_W'(root_frame) << OFFSET_W;
        for (int lvl = 0; lvl < 4; lvl++) begin
            idx   = IDX_W'(va >> (39 - 9 * lvl));
            word  = ((base >> 3) + VALUE_W'(idx)) % TABLE_WORDS;
            entry = table_words[word];
            if (!entry[0]) begin
                return res;
            end
            base = entry & FRAME_MASK;
        end
        res.phys_addr = base | VALUE_W'(va[OFFSET_W-1:0]);
        res.mapped    = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        if (!i_rst_n) begin
            for (int w = 0; w < TABLE_WORDS; w++) begin
                table_words[w] = '0;
            end
            root_frame = '0;
            results_due.delete();
            mismatches = 0;
            hits       = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result phys_addr=%h mapped=%b", $realtime,
                                 i_out_item.phys_addr, i_out_item.mapped);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (i_out_item.phys_addr !== want.phys_addr ||
                        i_out_item.mapped !== want.mapped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch phys_addr exp=%h got=%h mapped exp=%b got=%b",
                                     $realtime, want.phys_addr, i_out_item.phys_addr,
                                     want.mapped, i_out_item.mapped);
                        end
                    end
                    if (want.mapped) begin
                        hits++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.operation == OP_WRITE) begin
                    table_words[i_in_item.word_index % TABLE_WORDS] = i_in_item.write_data;
                    results_due.push_back(t_out_item'('0));
                end else begin
                    results_due.push_back(walk_tables(i_in_item.virt_addr));
                end
            end
            if (i_cfg_we) begin
                root_frame = i_cfg_wdata;
            end
        end
        o_errors  <= mismatches;
        o_pending <= results_due.size();
        o_hits    <= hits;
    end

endmodule

// ===== tb/sv/four_level_page_table_walker_core_tb.sv =====
// Testbench top for the page table walker: stimulus, back-pressure, root changes and verdict.
`timescale 1ns / 100ps

module four_level_page_table_walker_core_tb;
    import fltw_pkg::*;

    localparam int PHASE_ITEMS = 190;
    localparam int HOLD_CYCLES = 300;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_item;
    logic              cfg_we;
    logic [ROOT_W-1:0] cfg_wdata;
    logic              hold_req;
    logic              sender_calm;
    logic [ROOT_W-1:0] root_sel;
    int                chk_errors;
    int                chk_pending;
    int                chk_hits;
    int                n_writes;
    int                n_lookups;
    int                n_roots;

    always #10 clk = ~clk;

    four_level_page_table_walker_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    fltw_walk_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_hits      (chk_hits)
    );

    function automatic logic [VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VA_W-1:0] rand48();
        return VA_W'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (it.operation == OP_WRITE) begin
            n_writes++;
        end else begin
            n_lookups++;
        end
    endtask

    task automatic put_entry(input logic [WIDX_W-1:0] w, input logic [VALUE_W-1:0] d);
        t_in_item it;
        it.operation  = OP_WRITE;
        it.word_index = w;
        it.write_data = d;
        it.virt_addr  = rand48();
        send_item(it);
    endtask

    task automatic put_lookup(input logic [VA_W-1:0] va);
        t_in_item it;
        it.operation  = OP_XLATE;
        it.word_index = WIDX_W'($urandom);
        it.write_data = rand64();
        it.virt_addr  = va;
        send_item(it);
    endtask

    // writes the walk for va; the entry at level cut is left not present (cut 4: full map)
    task automatic write_walk(input logic [VA_W-1:0] va, input int cut);
        logic [ROOT_W-1:0]  frame;
        logic [VALUE_W-1:0] entry;
        logic [IDX_W-1:0]   idx;
        frame = root_sel;
        for (int lvl = 0; lvl < 4 && lvl <= cut; lvl++) begin
            idx      = IDX_W'(va >> (39 - 9 * lvl));
            entry    = rand64();
            entry[0] = (lvl != cut);
            put_entry({frame, idx}, entry);
            frame = entry[14:12];
        end
    endtask

    task automatic set_root(input logic [ROOT_W-1:0] r);
        in_valid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we   <= 1'b0;
        root_sel = r;
        n_roots++;
    endtask

    initial begin : out_stall_gen
        int mode;
        int run_left;
        int burst_left;
        int hold_left;
        bit hold_done;
        out_stall  = 1'b0;
        mode       = 0;
        run_left   = 0;
        burst_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(20, 200);
                end
                run_left--;
                if (burst_left > 0) begin
                    burst_left--;
                    out_stall <= 1'b1;
                end else begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 25);
                        2: out_stall <= ($urandom_range(0, 99) < 60);
                        default: begin
                            if ($urandom_range(0, 99) < 4) begin
                                burst_left = $urandom_range(10, 40);
                            end
                            out_stall <= ($urandom_range(0, 99) < 20);
                        end
                    endcase
                end
            end
        end
    end

    initial begin
        #16_000_000;
        $display("four_level_page_table_walker_core_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [VA_W-1:0]   va;
        logic [VA_W-1:0]   last_va;
        logic [ROOT_W-1:0] phase_roots [8];
        int                first;
        int                pick;
        int                spin;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        hold_req    = 1'b0;
        sender_calm = 1'b0;
        root_sel    = '0;
        n_writes    = 0;
        n_lookups   = 0;
        n_roots     = 0;
        phase_roots = '{3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty tables, extreme words and data, all-ones walk through the last word
        put_lookup('0);
        put_entry('0, '0);
        put_entry('1, '1);
        set_root(3'd7);
        put_lookup('1);
        put_lookup({36'hF_FFFF_FFFF, 12'h000});
        set_root(3'd0);
        put_lookup('0);
        for (int cut = 1; cut <= 4; cut++) begin
            va = rand48();
            write_walk(va, cut);
            put_lookup(va);
        end

        last_va = '0;
        for (int ph = 0; ph < 8; ph++) begin
            set_root(phase_roots[ph]);
            if (ph == 0) begin
                hold_req    <= 1'b1;
                sender_calm = 1'b1;
            end
            first = n_writes + n_lookups;
            while (n_writes + n_lookups - first < PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0) begin
                    sender_calm = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    va = rand48();
                    write_walk(va, ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 3));
                    repeat ($urandom_range(1, 3)) begin
                        put_lookup({va[VA_W-1:OFFSET_W], OFFSET_W'($urandom)});
                    end
                    last_va = va;
                end else if (pick < 80) begin
                    put_lookup(last_va ^ (VA_W'(1) << $urandom_range(OFFSET_W, VA_W - 1)));
                end else if (pick < 90) begin
                    put_lookup(rand48());
                end else begin
                    put_entry(WIDX_W'($urandom), rand64());
                end
            end
        end

        in_valid <= 1'b0;
        spin = 0;
        while (chk_pending != 0 && spin < 20000) begin
            @(posedge clk);
            spin++;
        end
        repeat (20) @(posedge clk);
        $display("Covered %0d table writes and %0d walks over %0d root frame settings.",
                 n_writes, n_lookups, n_roots);
        $display("%0d walks hit a mapped page; output held off %0d cycles under input load.",
                 chk_hits, HOLD_CYCLES);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("four_level_page_table_walker_core_tb: PASS");
        end else begin
            $display("four_level_page_table_walker_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fltw_pkg.sv
rtl/core/fltw_ram.sv
rtl/core/fltw_addr_unit.sv
rtl/core/four_level_page_table_walker_core.sv
tb/sv/fltw_walk_checker.sv
tb/sv/four_level_page_table_walker_core_tb.sv
